[rtl/core/tilt_rate_direction_decider_macros.svh]
// ----------------------------------------------------------------------------
// tilt rate direction decider assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef TILT_RATE_DIRECTION_DECIDER_MACROS_SVH
`define TILT_RATE_DIRECTION_DECIDER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define TRDD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trdd assertion failed");

// next-cycle implication
`define TRDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trdd assertion failed");

`else

`define TRDD_ASSERT_IMPL(label, clk, rst, ante, cons)

`define TRDD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/core/trdd_pkg.sv]
// ----------------------------------------------------------------------------
// trdd_pkg
// constants, types and codes of the tilt rate direction decider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trdd_pkg;

   localparam int WINDOW      = 20;
   localparam int SAMPLE_BITS = 16;
   localparam int WARMUP      = 3;

   localparam int Q_BITS    = 16;
   localparam int RD_BITS   = Q_BITS + 1;
   localparam int TOL_BITS  = 17;
   localparam int SLOT_BITS = $clog2(WINDOW);
   localparam int SUM_BITS  = $clog2(WINDOW * (2 ** Q_BITS) + 1);
   localparam int CMP_BITS  = $clog2(WINDOW * ((2 ** Q_BITS) + (2 ** TOL_BITS)));
   localparam int DIV_BITS  = SAMPLE_BITS + 1;
   localparam int CNT_BITS  = $clog2(RD_BITS);

   // average by reciprocal multiply, exact over the whole sum range
   localparam int AVG_SHIFT = SUM_BITS + $clog2(WINDOW);
   localparam longint unsigned AVG_MULT = ((64'd1 << AVG_SHIFT) + WINDOW - 1) / WINDOW;
   localparam int MULT_BITS = $clog2(AVG_MULT + 1);
   localparam int PROD_BITS = SUM_BITS + MULT_BITS;

   localparam int ADDR_BITS = 2;
   localparam int DATA_BITS = 32;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [RD_BITS-1:0]            reading_type;
   typedef logic [SUM_BITS-1:0]           sum_type;
   typedef logic [CMP_BITS-1:0]           cmp_type;
   typedef logic [TOL_BITS-1:0]           tol_type;
   typedef logic [1:0]                    drive_type;

   localparam logic [ADDR_BITS-1:0] REG_TOLERANCE_ADDR = 2'd0;
   localparam tol_type              TOL_RESET          = 17'd6554;

   localparam drive_type DRIVE_CW  = 2'd0;
   localparam drive_type DRIVE_CCW = 2'd1;
   localparam drive_type DRIVE_FWD = 2'd2;
   localparam drive_type DRIVE_REV = 2'd3;

endpackage

[rtl/core/tilt_rate_direction_decider.sv]
// ----------------------------------------------------------------------------
// tilt_rate_direction_decider
// steps: prep, the 17-step restoring divider, ring sum, decide, output; warmup skips divider and ring sum
// a new item is accepted only after the previous one is loaded into the output register;
// the next item is taken while the previous result waits in the output register
// reset: clears min/max, sum, slot, warmup count, parity and ring valid bits;
// tolerance returns to 6554; no clearing pass, ring entries not valid read as 0
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tilt_rate_direction_decider_macros.svh"

module tilt_rate_direction_decider import trdd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  sample_type           req_sample,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output drive_type            rsp_drive_code,
   output reading_type          rsp_reading,
   output reading_type          rsp_average,
   output logic                 rsp_decided,
   output logic                 rsp_long_dwell,

   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PREP   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_SUM    = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_OUT    = 3'd5;

   logic [2:0]           state_ff, state_in;
   sample_type           sample_ff, sample_in;
   sample_type           max_ff, max_in;
   sample_type           min_ff, min_in;
   logic                 warm_ff, warm_in;
   logic [1:0]           warmup_cnt_ff, warmup_cnt_in;
   logic                 parity_ff, parity_in;
   tol_type              tol_ff, tol_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   sum_type              sum_ff, sum_in;

   logic [DIV_BITS-1:0]    rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] range_ff, range_in;
   reading_type            quot_ff, quot_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;

   reading_type          reading_ff, reading_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   drive_type            code_ff, code_in;
   logic                 decided_ff, decided_in;
   logic                 long_ff, long_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   drive_type            rsp_code_ff, rsp_code_in;
   reading_type          rsp_reading_ff, rsp_reading_in;
   reading_type          rsp_average_ff, rsp_average_in;
   logic                 rsp_decided_ff, rsp_decided_in;
   logic                 rsp_long_ff, rsp_long_in;

   reading_type          ring_mem [WINDOW];
   reading_type          ring_rd_ff;
   logic                 ring_rd_vld_ff;
   logic [WINDOW-1:0]    ring_vld_ff;
   logic                 ring_rd;
   logic                 ring_wr;

   logic                   req_xfer;
   logic                   cfg_wr;
   logic signed [SAMPLE_BITS:0] diff_ext;
   logic signed [SAMPLE_BITS:0] rng_ext;
   logic [DIV_BITS-1:0]    div_trial;
   logic                   div_ge;
   reading_type            reading_now;
   reading_type            old_reading;
   cmp_type                lhs;
   cmp_type                tolw;
   cmp_type                sum_ext;
   logic                   rsp_load;

   assign req_xfer  = req_valid && !req_stall;
   assign cfg_wr    = psel && penable && pwrite && pready;
   assign req_stall = (state_ff != ST_IDLE);
   assign pready    = 1'b1;
   assign prdata    = (paddr == REG_TOLERANCE_ADDR) ? DATA_BITS'(tol_ff) : '0;

   assign diff_ext = {sample_ff[SAMPLE_BITS-1], sample_ff} - {min_ff[SAMPLE_BITS-1], min_ff};
   assign rng_ext  = {max_ff[SAMPLE_BITS-1], max_ff} - {min_ff[SAMPLE_BITS-1], min_ff};

   // first step compares the plain numerator, later steps shift in zeros
   assign div_trial = (cnt_ff == '0) ? rem_ff : {rem_ff[DIV_BITS-2:0], 1'b0};
   assign div_ge    = (div_trial >= {1'b0, range_ff});

   assign reading_now = (range_ff == '0) ? '0 : quot_ff;
   assign old_reading = ring_rd_vld_ff ? ring_rd_ff : '0;

   assign lhs     = CMP_BITS'(reading_ff) * CMP_BITS'(WINDOW);
   assign tolw    = CMP_BITS'(tol_ff) * CMP_BITS'(WINDOW);
   assign sum_ext = CMP_BITS'(sum_ff);

   assign rsp_load = (state_ff == ST_OUT) && !(rsp_valid_ff && rsp_stall);
   assign ring_rd  = (state_ff == ST_PREP);
   assign ring_wr  = (state_ff == ST_SUM);

   always_comb begin
      state_in       = state_ff;
      sample_in      = sample_ff;
      max_in         = max_ff;
      min_in         = min_ff;
      warm_in        = warm_ff;
      warmup_cnt_in  = warmup_cnt_ff;
      parity_in      = parity_ff;
      tol_in         = tol_ff;
      slot_in        = slot_ff;
      sum_in         = sum_ff;
      rem_in         = rem_ff;
      range_in       = range_ff;
      quot_in        = quot_ff;
      cnt_in         = cnt_ff;
      reading_in     = reading_ff;
      prod_in        = prod_ff;
      code_in        = code_ff;
      decided_in     = decided_ff;
      long_in        = long_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_code_in    = rsp_code_ff;
      rsp_reading_in = rsp_reading_ff;
      rsp_average_in = rsp_average_ff;
      rsp_decided_in = rsp_decided_ff;
      rsp_long_in    = rsp_long_ff;

      if (cfg_wr && (paddr == REG_TOLERANCE_ADDR)) begin
         tol_in = pwdata[TOL_BITS-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               sample_in = req_sample;
               if (req_sample > max_ff) begin
                  max_in = req_sample;
               end
               if (req_sample < min_ff) begin
                  min_in = req_sample;
               end
               warm_in = (warmup_cnt_ff < 2'(WARMUP));
               if (warmup_cnt_ff < 2'(WARMUP)) begin
                  warmup_cnt_in = warmup_cnt_ff + 2'd1;
               end
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            rem_in     = DIV_BITS'(diff_ext[SAMPLE_BITS-1:0]);
            range_in   = rng_ext[SAMPLE_BITS-1:0];
            quot_in    = '0;
            cnt_in     = '0;
            reading_in = '0;
            state_in   = warm_ff ? ST_DECIDE : ST_DIV;
         end
         ST_DIV: begin
            rem_in  = div_ge ? (div_trial - {1'b0, range_ff}) : div_trial;
            quot_in = {quot_ff[RD_BITS-2:0], div_ge};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(RD_BITS - 1)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            reading_in = reading_now;
            sum_in     = sum_ff - SUM_BITS'(old_reading) + SUM_BITS'(reading_now);
            slot_in    = (slot_ff == SLOT_BITS'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            prod_in = PROD_BITS'(sum_ff) * PROD_BITS'(AVG_MULT);
            if (warm_ff) begin
               code_in    = parity_ff ? DRIVE_REV : DRIVE_FWD;
               long_in    = 1'b1;
               decided_in = 1'b0;
            end else if (lhs > sum_ext + tolw) begin
               code_in    = DRIVE_CW;
               long_in    = 1'b0;
               decided_in = 1'b1;
            end else if (lhs + tolw < sum_ext) begin
               code_in    = DRIVE_CCW;
               long_in    = 1'b0;
               decided_in = 1'b1;
            end else begin
               parity_in  = !parity_ff;
               code_in    = parity_ff ? DRIVE_FWD : DRIVE_REV;
               long_in    = 1'b1;
               decided_in = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_valid_in   = 1'b1;
               rsp_code_in    = code_ff;
               rsp_reading_in = reading_ff;
               rsp_average_in = prod_ff[AVG_SHIFT +: RD_BITS];
               rsp_decided_in = decided_ff;
               rsp_long_in    = long_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         max_ff        <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         min_ff        <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         warm_ff       <= 1'b0;
         warmup_cnt_ff <= '0;
         parity_ff     <= 1'b0;
         tol_ff        <= TOL_RESET;
         slot_ff       <= '0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_ff        <= max_in;
         min_ff        <= min_in;
         warm_ff       <= warm_in;
         warmup_cnt_ff <= warmup_cnt_in;
         parity_ff     <= parity_in;
         tol_ff        <= tol_in;
         slot_ff       <= slot_in;
         sum_ff        <= sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff      <= sample_in;
      rem_ff         <= rem_in;
      range_ff       <= range_in;
      quot_ff        <= quot_in;
      cnt_ff         <= cnt_in;
      reading_ff     <= reading_in;
      prod_ff        <= prod_in;
      code_ff        <= code_in;
      decided_ff     <= decided_in;
      long_ff        <= long_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_reading_ff <= rsp_reading_in;
      rsp_average_ff <= rsp_average_in;
      rsp_decided_ff <= rsp_decided_in;
      rsp_long_ff    <= rsp_long_in;
   end

   // reading ring
   always_ff @(posedge clock) begin
      if (ring_wr) begin
         ring_mem[slot_ff] <= reading_now;
      end
      if (ring_rd) begin
         ring_rd_ff <= ring_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff    <= '0;
         ring_rd_vld_ff <= 1'b0;
      end else begin
         if (ring_wr) begin
            ring_vld_ff[slot_ff] <= 1'b1;
         end
         if (ring_rd) begin
            ring_rd_vld_ff <= ring_vld_ff[slot_ff];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_drive_code = rsp_code_ff;
   assign rsp_reading    = rsp_reading_ff;
   assign rsp_average    = rsp_average_ff;
   assign rsp_decided    = rsp_decided_ff;
   assign rsp_long_dwell = rsp_long_ff;

   `TRDD_ASSERT_IMPL(a_slot_range, clock, reset, 1'b1, slot_ff <= SLOT_BITS'(WINDOW - 1))
   `TRDD_ASSERT_IMPL(a_sum_bound, clock, reset, 1'b1, sum_ff <= SUM_BITS'(WINDOW * (2 ** Q_BITS)))
   `TRDD_ASSERT_IMPL(a_div_rem, clock, reset, (state_ff == ST_DIV) && (cnt_ff != '0) && (range_ff != '0), rem_ff < DIV_BITS'(range_ff))
   `TRDD_ASSERT_IMPL(a_turn_decided, clock, reset, rsp_valid && !rsp_long_dwell, rsp_decided && (rsp_drive_code == DRIVE_CW || rsp_drive_code == DRIVE_CCW))
   `TRDD_ASSERT_NEXT(a_out_load, clock, reset, rsp_load, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

[test/tilt_rate_direction_decider_tb.sv]
// ----------------------------------------------------------------------------
// tilt_rate_direction_decider_tb
// self-checking bench: feeds gyro rate samples through the input channel,
// predicts drive code, reading, average and flags in step with each accepted
// transfer, and compares every result transfer field by field; runs a short
// directed warmup and zero-range sequence, then random walks, noise and
// extremes under several tolerance settings and handshake idling mixes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilt_rate_direction_decider_tb;
   import trdd_pkg::*;

   localparam int HALF_PERIOD     = 10;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int N_PHASES        = 8;

   localparam int DIRECTED_SAMPLES [20] = '{0, 0, 0, 0, 0, 3, -2, 5, 5, 5, 5, -2,
                                             32767, -32768, 0, 32767, 32767, -32768,
                                             1, -1};
   // negative entry picks a random tolerance, above 65536 widens the dead band
   localparam int TOL_PLAN [N_PHASES] = '{6554, 0, 65536, 131071, -1, 1, 65535, -1};
   localparam int SEND_IDLE [4] = '{0, 60, 0, 31};
   localparam int RECV_STALL [4] = '{0, 0, 60, 31};

   typedef struct packed {
      drive_type   drive;
      reading_type reading;
      reading_type average;
      logic        decided;
      logic        long_dwell;
   } tilt_result_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   sample_type           req_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   drive_type            rsp_drive_code;
   reading_type          rsp_reading;
   reading_type          rsp_average;
   logic                 rsp_decided;
   logic                 rsp_long_dwell;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [DATA_BITS-1:0] pwdata = '0;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   sample_type   pending_samples[$];
   tilt_result_t expected_results[$];
   logic         req_sent = 1'b0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;

   // decider state as the bench sees it
   sample_type hi_seen = sample_type'(-32768);
   sample_type lo_seen = sample_type'(32767);
   longint     reading_ring [WINDOW];
   longint     ring_sum = 0;
   int         ring_ptr = 0;
   int         warm_count = 0;
   logic       steady_rev = 1'b0;
   tol_type    tol_q16 = TOL_RESET;

   int         walk_level = 0;
   sample_type last_sample = '0;

   int errors = 0;
   int samples_taken = 0;
   int results_checked = 0;
   int n_cw = 0;
   int n_ccw = 0;
   int n_steady = 0;

   tilt_rate_direction_decider dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_drive_code (rsp_drive_code),
      .rsp_reading    (rsp_reading),
      .rsp_average    (rsp_average),
      .rsp_decided    (rsp_decided),
      .rsp_long_dwell (rsp_long_dwell),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic tilt_result_t step_tilt(input sample_type s);
      tilt_result_t r;
      longint       x;
      longint       span;
      longint       rd;
      longint       lhs;
      longint       tolw;
      x = longint'(s);
      rd = 0;
      if (s > hi_seen) hi_seen = s;
      if (s < lo_seen) lo_seen = s;
      r.decided = 1'b0;
      r.long_dwell = 1'b1;
      if (warm_count < WARMUP) begin
         warm_count++;
         r.drive = steady_rev ? DRIVE_REV : DRIVE_FWD;
      end else begin
         span = longint'(hi_seen) - longint'(lo_seen);
         if (span != 0) rd = ((x - longint'(lo_seen)) * 65536) / span;
         ring_sum = ring_sum - reading_ring[ring_ptr] + rd;
         reading_ring[ring_ptr] = rd;
         ring_ptr = (ring_ptr + 1) % WINDOW;
         lhs = rd * WINDOW;
         tolw = longint'(tol_q16) * WINDOW;
         r.decided = 1'b1;
         if (lhs > ring_sum + tolw) begin
            r.drive = DRIVE_CW;
            r.long_dwell = 1'b0;
         end else if (lhs + tolw < ring_sum) begin
            r.drive = DRIVE_CCW;
            r.long_dwell = 1'b0;
         end else begin
            steady_rev = ~steady_rev;
            r.drive = steady_rev ? DRIVE_REV : DRIVE_FWD;
         end
      end
      r.reading = reading_type'(rd);
      r.average = reading_type'(ring_sum / WINDOW);
      return r;
   endfunction

   // a slow random walk and full-range noise in equal parts, with holds and extremes
   function automatic sample_type next_random_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         last_sample = sample_type'($urandom);
      end else if (pick < 80) begin
         walk_level = walk_level + int'($urandom_range(0, 4000)) - 2000;
         if (walk_level > 32767) walk_level = 32767;
         if (walk_level < -32768) walk_level = -32768;
         last_sample = sample_type'(walk_level);
      end else if (pick >= 90) begin
         case ($urandom_range(0, 3))
            0: last_sample = sample_type'(-32768);
            1: last_sample = sample_type'(32767);
            2: last_sample = sample_type'(0);
            default: last_sample = sample_type'(-1);
         endcase
      end
      return last_sample;
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   // input side driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_sent) begin
         if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_sample <= pending_samples.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // accepted samples feed the predictor
   always @(posedge clock) begin
      req_sent <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_results.push_back(step_tilt(req_sample));
         samples_taken++;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      tilt_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result transfer with nothing outstanding");
         end else begin
            want = expected_results.pop_front();
            if (rsp_drive_code !== want.drive)
               report_mismatch($sformatf("result %0d drive_code got %0d expected %0d",
                                         results_checked, rsp_drive_code, want.drive));
            if (rsp_reading !== want.reading)
               report_mismatch($sformatf("result %0d reading got %0d expected %0d",
                                         results_checked, rsp_reading, want.reading));
            if (rsp_average !== want.average)
               report_mismatch($sformatf("result %0d average got %0d expected %0d",
                                         results_checked, rsp_average, want.average));
            if (rsp_decided !== want.decided)
               report_mismatch($sformatf("result %0d decided got %0d expected %0d",
                                         results_checked, rsp_decided, want.decided));
            if (rsp_long_dwell !== want.long_dwell)
               report_mismatch($sformatf("result %0d long_dwell got %0d expected %0d",
                                         results_checked, rsp_long_dwell,
                                         want.long_dwell));
            case (want.drive)
               DRIVE_CW:  n_cw++;
               DRIVE_CCW: n_ccw++;
               default:   if (want.decided) n_steady++;
            endcase
            results_checked++;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      logic [DATA_BITS-1:0] wdata;
      for (int i = 0; i < WINDOW; i++) reading_ring[i] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // warmup, zero range, small range, then the sample extremes
      foreach (DIRECTED_SAMPLES[i]) pending_samples.push_back(sample_type'(DIRECTED_SAMPLES[i]));

      for (int phase = 0; phase < N_PHASES; phase++) begin
         wait_drained();
         wdata = $urandom;
         wdata[TOL_BITS-1:0] = (TOL_PLAN[phase] < 0) ? tol_type'($urandom_range(0, 131071))
                                                     : tol_type'(TOL_PLAN[phase]);
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= 1'b1;
         paddr <= REG_TOLERANCE_ADDR;
         pwdata <= wdata;
         @(negedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) @(posedge clock);
         tol_q16 = wdata[TOL_BITS-1:0];
         @(negedge clock);
         penable <= 1'b0;
         pwrite <= 1'b0;
         @(negedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) @(posedge clock);
         if (prdata !== DATA_BITS'(tol_q16))
            report_mismatch($sformatf("tolerance read back %0d expected %0d", prdata, tol_q16));
         @(negedge clock);
         psel <= 1'b0;
         penable <= 1'b0;

         send_idle_pct = SEND_IDLE[phase % 4];
         stall_pct = RECV_STALL[phase % 4];
         repeat (ITEMS_PER_PHASE) pending_samples.push_back(next_random_sample());
      end

      wait_drained();
      stall_pct = 0;
      repeat (30) @(posedge clock);
      $display("%0d samples sent and %0d results checked over %0d tolerance settings",
               samples_taken, results_checked, N_PHASES + 1);
      $display("decided turns: %0d clockwise, %0d counterclockwise; %0d steady holds",
               n_cw, n_ccw, n_steady);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/trdd_pkg.sv
rtl/core/tilt_rate_direction_decider.sv
test/tilt_rate_direction_decider_tb.sv
